// ----- hw/rtl/vsds_pkg.sv -----
// vsds_pkg: field widths, request and status codes, and the command and
// status structs that join the stack controller and its datapath.
// No dependencies.
package vsds_pkg;

   // fixed field widths of the request and response channels
   localparam int TYPE_W   = 3;
   localparam int WORD_W   = 64;
   localparam int CNT_W    = 7;
   localparam int STATUS_W = 3;

   // request codes; the two remaining codes are unknown requests
   localparam logic [TYPE_W-1:0] REQ_PUSH  = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_POP   = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_PRINT = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_DUP   = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_SWAP  = 3'd5;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FEW     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;

   // memory address selection
   typedef enum logic [1:0] {
      ADDR_COUNT  = 2'd0,
      ADDR_TOP    = 2'd1,
      ADDR_SECOND = 2'd2,
      ADDR_PTR    = 2'd3
   } addr_sel_type;

   // memory write data selection
   typedef enum logic {
      WD_VALUE = 1'b0,
      WD_RDATA = 1'b1
   } wdata_sel_type;

   // entry counter update
   typedef enum logic [1:0] {
      CNT_HOLD  = 2'd0,
      CNT_INC   = 2'd1,
      CNT_DEC   = 2'd2,
      CNT_CLEAR = 2'd3
   } cnt_op_type;

   // controller to datapath commands
   typedef struct packed {
      logic                latch_req;
      logic                mem_we;
      addr_sel_type        waddr_sel;
      wdata_sel_type       wdata_sel;
      logic                mem_re;
      addr_sel_type        raddr_sel;
      logic                cap_value;
      cnt_op_type          cnt_op;
      logic                load_walk;
      logic                step_walk;
      logic                emit;
      logic                emit_has;
      logic [STATUS_W-1:0] emit_status;
      logic                emit_last;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [TYPE_W-1:0] req_op;
      logic              empty;
      logic              full;
      logic              below_two;
      logic              print_none;
      logic              walk_last;
      logic              out_free;
   } dp_status_type;

endpackage

// ----- hw/rtl/value_stack_with_dup_swap.sv -----
// value_stack_with_dup_swap: bounded LIFO stack of 64-bit words with push,
// pop, print, clear, dup and swap. Uses vsds_pkg, vsds_ctrl, vsds_datapath.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  type, push_value, print_count
//   rsp_      out         rsp_valid / rsp_stall  result_value, has_value,
//                                                status, entry_count, last
//
// One request at a time. Each request steps through its own states in turn,
// with push, clear, unknown and failed requests the shortest and swap and print
// the longest, set by the single read port of the stack RAM; the last response
// register load comes in the same cycle as the sequencer returns to idle.
// Reset empties the stack at once; RAM contents are not cleared.
// A stalled response holds its register; the sequencer waits before the next.
module value_stack_with_dup_swap #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [vsds_pkg::TYPE_W-1:0]          req_type,
   input  logic [vsds_pkg::WORD_W-1:0]          req_push_value,
   input  logic [vsds_pkg::CNT_W-1:0]           req_print_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [vsds_pkg::WORD_W-1:0]          rsp_result_value,
   output logic                                 rsp_has_value,
   output logic [vsds_pkg::STATUS_W-1:0]        rsp_status,
   output logic [vsds_pkg::CNT_W-1:0]           rsp_entry_count,
   output logic                                 rsp_last
);
   import vsds_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   // sequencer
   vsds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, counter and response register
   vsds_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_push_value   (req_push_value),
      .req_print_count  (req_print_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_has_value    (rsp_has_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- hw/rtl/vsds_ram.sv -----
// vsds_ram: generic single write port, single read port RAM with a
// registered read. No dependencies.
module vsds_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/vsds_datapath.sv -----
// vsds_datapath: request registers, entry counter, print walker, stack
// memory and response output register. Uses vsds_pkg and vsds_ram.
module vsds_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vsds_pkg::ctrl_cmd_type               cmd,
   output vsds_pkg::dp_status_type              stat,
   input  logic [vsds_pkg::TYPE_W-1:0]          req_type,
   input  logic [vsds_pkg::WORD_W-1:0]          req_push_value,
   input  logic [vsds_pkg::CNT_W-1:0]           req_print_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [vsds_pkg::WORD_W-1:0]          rsp_result_value,
   output logic                                 rsp_has_value,
   output logic [vsds_pkg::STATUS_W-1:0]        rsp_status,
   output logic [vsds_pkg::CNT_W-1:0]           rsp_entry_count,
   output logic                                 rsp_last
);
   import vsds_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [TYPE_W-1:0]   op_ff;
   logic [WORD_W-1:0]   value_ff, value_in;
   logic [CNT_W-1:0]    print_count_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       want_ff, want_in;
   logic [CNT_W-1:0]    count_wide;
   logic [CNT_W-1:0]    want_wide;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   rsp_value_ff;
   logic                rsp_has_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic                rsp_last_ff;
   logic [AW-1:0]       addr_count, addr_top, addr_second;
   logic [AW-1:0]       waddr, raddr;
   logic [WORD_W-1:0]   wdata, rdata;
   logic                out_free;

   // stack addresses derived from the entry count
   assign addr_count  = AW'(count_ff);
   assign addr_top    = AW'(count_ff - CW'(1));
   assign addr_second = AW'(count_ff - CW'(2));

   always_comb begin
      case (cmd.waddr_sel)
         ADDR_COUNT:  waddr = addr_count;
         ADDR_TOP:    waddr = addr_top;
         ADDR_SECOND: waddr = addr_second;
         default:     waddr = ptr_ff;
      endcase
      case (cmd.raddr_sel)
         ADDR_COUNT:  raddr = addr_count;
         ADDR_TOP:    raddr = addr_top;
         ADDR_SECOND: raddr = addr_second;
         default:     raddr = ptr_ff;
      endcase
   end

   assign wdata = (cmd.wdata_sel == WD_RDATA) ? rdata : value_ff;

   vsds_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (cmd.mem_we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (cmd.mem_re),
      .raddr (raddr),
      .rdata (rdata)
   );

   // request capture and read data capture
   assign value_in = cmd.cap_value ? rdata : req_push_value;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff          <= req_type;
         print_count_ff <= req_print_count;
      end
      if (cmd.latch_req || cmd.cap_value) begin
         value_ff <= value_in;
      end
   end

   // entry counter
   always_comb begin
      case (cmd.cnt_op)
         CNT_INC:   count_in = count_ff + CW'(1);
         CNT_DEC:   count_in = count_ff - CW'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // print walker: shown entries clamp to the entry count
   assign count_wide = CNT_W'(count_ff);
   assign want_wide  = (print_count_ff < count_wide) ? print_count_ff : count_wide;

   always_comb begin
      ptr_in  = ptr_ff;
      want_in = want_ff;
      if (cmd.load_walk) begin
         ptr_in  = addr_top;
         want_in = CW'(want_wide);
      end else if (cmd.step_walk) begin
         ptr_in  = ptr_ff - AW'(1);
         want_in = want_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      want_ff <= want_in;
   end

   // response output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff  <= cmd.emit_has ? value_ff : '0;
         rsp_has_ff    <= cmd.emit_has;
         rsp_status_ff <= cmd.emit_status;
         rsp_count_ff  <= CNT_W'(count_ff);
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_has_value    = rsp_has_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

   // status toward the controller
   always_comb begin
      stat.req_op     = op_ff;
      stat.empty      = (count_ff == '0);
      stat.full       = (count_ff == CW'(DEPTH));
      stat.below_two  = (count_ff < CW'(2));
      stat.print_none = (print_count_ff == '0);
      stat.walk_last  = (want_ff == CW'(1));
      stat.out_free   = out_free;
   end

endmodule

// ----- hw/rtl/vsds_ctrl.sv -----
// vsds_ctrl: request sequencing state machine for the stack.
// Uses vsds_pkg; drives the datapath through ctrl_cmd_type.
module vsds_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  vsds_pkg::dp_status_type stat,
   output vsds_pkg::ctrl_cmd_type  cmd
);
   import vsds_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE      = 11'b000_0000_0001,
      S_DECODE    = 11'b000_0000_0010,
      S_POP_CAP   = 11'b000_0000_0100,
      S_DUP_WR    = 11'b000_0000_1000,
      S_SWAP_RD   = 11'b000_0001_0000,
      S_SWAP_WR   = 11'b000_0010_0000,
      S_SWAP_WR2  = 11'b000_0100_0000,
      S_EMIT      = 11'b000_1000_0000,
      S_WALK_RD   = 11'b001_0000_0000,
      S_WALK_CAP  = 11'b010_0000_0000,
      S_WALK_OUT  = 11'b100_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                has_ff, has_in;

   assign req_stall = (state_ff != S_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      has_in    = has_ff;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ST_OK;
            has_in    = 1'b0;
            state_in  = S_EMIT;
            case (stat.req_op)
               REQ_PUSH: begin
                  if (stat.full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.mem_we    = 1'b1;
                     cmd.waddr_sel = ADDR_COUNT;
                     cmd.wdata_sel = WD_VALUE;
                     cmd.cnt_op    = CNT_INC;
                  end
               end
               REQ_POP: begin
                  if (stat.empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     cmd.mem_re    = 1'b1;
                     cmd.raddr_sel = ADDR_TOP;
                     cmd.cnt_op    = CNT_DEC;
                     has_in        = 1'b1;
                     state_in      = S_POP_CAP;
                  end
               end
               REQ_PRINT: begin
                  if (stat.empty) begin
                     status_in = ST_EMPTY;
                  end else if (!stat.print_none) begin
                     cmd.load_walk = 1'b1;
                     state_in      = S_WALK_RD;
                  end
               end
               REQ_CLEAR: begin
                  cmd.cnt_op = CNT_CLEAR;
               end
               REQ_DUP: begin
                  if (stat.empty) begin
                     status_in = ST_EMPTY;
                  end else if (stat.full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.mem_re    = 1'b1;
                     cmd.raddr_sel = ADDR_TOP;
                     state_in      = S_DUP_WR;
                  end
               end
               REQ_SWAP: begin
                  if (stat.below_two) begin
                     status_in = ST_FEW;
                  end else begin
                     cmd.mem_re    = 1'b1;
                     cmd.raddr_sel = ADDR_TOP;
                     state_in      = S_SWAP_RD;
                  end
               end
               default: begin
                  status_in = ST_UNKNOWN;
               end
            endcase
         end
         S_POP_CAP: begin
            cmd.cap_value = 1'b1;
            state_in      = S_EMIT;
         end
         // copy the top entry into the free slot above it
         S_DUP_WR: begin
            cmd.mem_we    = 1'b1;
            cmd.waddr_sel = ADDR_COUNT;
            cmd.wdata_sel = WD_RDATA;
            cmd.cnt_op    = CNT_INC;
            state_in      = S_EMIT;
         end
         // hold the top entry, fetch the one below
         S_SWAP_RD: begin
            cmd.cap_value = 1'b1;
            cmd.mem_re    = 1'b1;
            cmd.raddr_sel = ADDR_SECOND;
            state_in      = S_SWAP_WR;
         end
         S_SWAP_WR: begin
            cmd.mem_we    = 1'b1;
            cmd.waddr_sel = ADDR_TOP;
            cmd.wdata_sel = WD_RDATA;
            state_in      = S_SWAP_WR2;
         end
         S_SWAP_WR2: begin
            cmd.mem_we    = 1'b1;
            cmd.waddr_sel = ADDR_SECOND;
            cmd.wdata_sel = WD_VALUE;
            state_in      = S_EMIT;
         end
         // single response of a non-print request or an empty marker
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_has    = has_ff;
               cmd.emit_status = status_ff;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         // print walk, one entry per pass, top first
         S_WALK_RD: begin
            cmd.mem_re    = 1'b1;
            cmd.raddr_sel = ADDR_PTR;
            state_in      = S_WALK_CAP;
         end
         S_WALK_CAP: begin
            cmd.cap_value = 1'b1;
            state_in      = S_WALK_OUT;
         end
         S_WALK_OUT: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_has    = 1'b1;
               cmd.emit_status = ST_OK;
               cmd.emit_last   = stat.walk_last;
               cmd.step_walk   = 1'b1;
               state_in        = stat.walk_last ? S_IDLE : S_WALK_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      has_ff    <= has_in;
   end

endmodule

// ----- hw/rtl/vsds_checker.sv -----
// vsds_checker: port-level assertions for the stack, bound to the top
// level. Uses vsds_pkg.
module vsds_checker #(
   parameter int DEPTH = 64
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [vsds_pkg::TYPE_W-1:0]          req_type,
   input logic [vsds_pkg::WORD_W-1:0]          req_push_value,
   input logic [vsds_pkg::CNT_W-1:0]           req_print_count,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [vsds_pkg::WORD_W-1:0]          rsp_result_value,
   input logic                                 rsp_has_value,
   input logic [vsds_pkg::STATUS_W-1:0]        rsp_status,
   input logic [vsds_pkg::CNT_W-1:0]           rsp_entry_count,
   input logic                                 rsp_last
);
   import vsds_pkg::*;

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_status) && $stable(rsp_entry_count) && $stable(rsp_last))
      else $error("stalled response changed");

   // one request at a time: busy right after an accepted transaction
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in progress");

   // entry count never exceeds the stack depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // a response without an entry is a single zero-valued final result
   a_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_value |-> rsp_result_value == '0 && rsp_last)
      else $error("empty response malformed");

   // failed requests never carry an entry
   a_fail_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_has_value)
      else $error("failed request carried a value");

endmodule

bind value_stack_with_dup_swap vsds_checker #(.DEPTH(DEPTH)) u_vsds_checker (.*);
